### rtl/gp2arm_pkg.sv
// shared constants and mapping functions for the gamepad to arm joint command block
package gp2arm_pkg;

	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 48;
	localparam int AXIS_W      = 16;
	localparam int CMD_W       = 8;
	localparam int NUM_JOINTS  = 6;
	localparam int DZ_W        = 11;

	localparam logic [DZ_W-1:0] DZ_RESET = 11'd819;

	localparam logic signed [AXIS_W-1:0] AXIS_ONE  = 16'sd16384;
	localparam logic signed [AXIS_W-1:0] AXIS_MONE = -16'sd16384;
	localparam logic signed [AXIS_W-1:0] DPAD_HALF = 16'sd8192;
	localparam logic signed [AXIS_W-1:0] DPAD_MHALF = -16'sd8192;
	localparam logic [15:0] STICK_RND = 16'd2047;

	// joint slots in the command vector
	localparam int J_SHOULDER = 0;
	localparam int J_UPPER    = 1;
	localparam int J_MID      = 2;
	localparam int J_LOWER    = 3;
	localparam int J_WRIST    = 4;
	localparam int J_FINGER   = 5;

	typedef enum logic {
		KIND_STOP   = 1'b0,
		KIND_JOINTS = 1'b1
	} result_kind_t;

	typedef logic [NUM_JOINTS-1:0][CMD_W-1:0] cmd_vec_t;

	function automatic logic signed [AXIS_W-1:0] axis_sat(input logic signed [AXIS_W-1:0] v);
		if (v > AXIS_ONE) return AXIS_ONE;
		if (v < AXIS_MONE) return AXIS_MONE;
		return v;
	endfunction

	// floor(127 * k / 8) for k in 0..8
	function automatic logic [6:0] step_mag(input logic [3:0] k);
		logic [6:0] m;
		case (k)
			4'd1:    m = 7'd15;
			4'd2:    m = 7'd31;
			4'd3:    m = 7'd47;
			4'd4:    m = 7'd63;
			4'd5:    m = 7'd79;
			4'd6:    m = 7'd95;
			4'd7:    m = 7'd111;
			4'd8:    m = 7'd127;
			default: m = 7'd0;
		endcase
		return m;
	endfunction

	function automatic logic [CMD_W-1:0] stick_cmd(input logic signed [AXIS_W-1:0] s,
			input logic [DZ_W-1:0] dz);
		logic [14:0] a;
		logic [15:0] rnd;
		logic [CMD_W-1:0] mag;
		a = s[15] ? 15'(-s) : s[14:0];
		if ({4'd0, dz} >= a) return '0;
		// ceil(a / 2048), 1..8
		rnd = {1'b0, a} + STICK_RND;
		mag = {1'b0, step_mag(rnd[14:11])};
		return s[15] ? 8'(-mag) : mag;
	endfunction

	// 4 - floor(t / 4096) mapped to 0..127
	function automatic logic [CMD_W-1:0] trig_mag(input logic signed [AXIS_W-1:0] t);
		logic [3:0] m;
		m = 4'd4 - t[15:12];
		return {1'b0, step_mag(m)};
	endfunction

	function automatic logic [CMD_W-1:0] pair_cmd(input logic pos, input logic neg);
		if (pos) return 8'd1;
		if (neg) return 8'hFF;
		return 8'd0;
	endfunction

endpackage

### rtl/gamepad_to_arm_joint_commands.sv
// top level: gamepad sample in, arm joint command set or stop request out
//
// channel   | dir | beat contents                                   | rate
// s_axis    | in  | one gamepad sample (axes, buttons)              | 1 per cycle unless stalled
// m_axis    | out | zero or one result per sample (stop or joints)  | 1 per cycle unless stalled
// cfg       | in  | dead zone limit write                           | any idle cycle
//
// a sample is registered on acceptance, mapped from the input register and its result,
// if any, lands in the output register when the sample advances.
// one sample per cycle sustained while the output is not stalled; the output register
// and the input register both advance whenever the output is empty or being taken.
// arst_n clears valids, last commands, trigger flags and rearms the stop button.
// samples that give no result pass the mapping stage even while the output stalls.
module gamepad_to_arm_joint_commands (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// left_stick_x, right_stick_y, dpad_y, left_trigger, right_trigger,
	// a, y, start, back and middle buttons, zero pad
	input  logic [gp2arm_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// shoulder, upper arm, mid arm, lower arm, wrist and finger commands
	output logic [gp2arm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// result_kind
	output logic        m_axis_tuser
);

	logic [gp2arm_pkg::DZ_W-1:0] dead_zone_q;

	logic        in_valid_s1;
	logic [84:0] in_data_s1;

	logic                     out_valid_q;
	gp2arm_pkg::result_kind_t out_kind_q;
	gp2arm_pkg::cmd_vec_t     out_cmd_q;

	gp2arm_pkg::cmd_vec_t last_cmd_q;
	logic pos_moved_q;
	logic neg_moved_q;
	logic stop_rearmed_q;

	logic signed [15:0] lx, ry, dy, lt, rt;
	logic ba, by, bs, bb, bm;
	logic pos_moved_d, neg_moved_d;
	gp2arm_pkg::cmd_vec_t cmd;
	logic changed;
	logic produce;
	logic advance;
	logic out_free;

	assign lx = gp2arm_pkg::axis_sat(in_data_s1[15:0]);
	assign ry = gp2arm_pkg::axis_sat(in_data_s1[31:16]);
	assign dy = gp2arm_pkg::axis_sat(in_data_s1[47:32]);
	assign lt = gp2arm_pkg::axis_sat(in_data_s1[63:48]);
	assign rt = gp2arm_pkg::axis_sat(in_data_s1[79:64]);
	assign ba = in_data_s1[80];
	assign by = in_data_s1[81];
	assign bs = in_data_s1[82];
	assign bb = in_data_s1[83];
	assign bm = in_data_s1[84];

	// trigger flags are set before they gate this sample
	assign pos_moved_d = pos_moved_q | (lt != 16'sd0);
	assign neg_moved_d = neg_moved_q | (rt != 16'sd0);

	always_comb begin
		cmd = '0;
		cmd[gp2arm_pkg::J_SHOULDER] = gp2arm_pkg::stick_cmd(lx, dead_zone_q);
		cmd[gp2arm_pkg::J_UPPER]    = gp2arm_pkg::pair_cmd(dy > gp2arm_pkg::DPAD_HALF,
				dy < gp2arm_pkg::DPAD_MHALF);
		cmd[gp2arm_pkg::J_MID]      = gp2arm_pkg::pair_cmd(ba, by);
		cmd[gp2arm_pkg::J_LOWER]    = gp2arm_pkg::stick_cmd(ry, dead_zone_q);
		if (lt != gp2arm_pkg::AXIS_ONE && pos_moved_d) begin
			cmd[gp2arm_pkg::J_WRIST] = gp2arm_pkg::trig_mag(lt);
		end else if (rt != gp2arm_pkg::AXIS_ONE && neg_moved_d) begin
			cmd[gp2arm_pkg::J_WRIST] = 8'(-gp2arm_pkg::trig_mag(rt));
		end else begin
			cmd[gp2arm_pkg::J_WRIST] = 8'd0;
		end
		cmd[gp2arm_pkg::J_FINGER]   = gp2arm_pkg::pair_cmd(bs, bb);
	end

	assign changed  = (cmd != last_cmd_q);
	assign produce  = bm ? stop_rearmed_q : changed;
	assign out_free = !out_valid_q || m_axis_tready;
	assign advance  = in_valid_s1 && (!produce || out_free);

	assign s_axis_tready = !in_valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = out_cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= gp2arm_pkg::DZ_RESET;
		end else if (cfg_wr_en) begin
			dead_zone_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_data_s1 <= s_axis_tdata[84:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			last_cmd_q     <= '0;
			pos_moved_q    <= 1'b0;
			neg_moved_q    <= 1'b0;
			stop_rearmed_q <= 1'b1;
		end else begin
			if (advance && produce) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				stop_rearmed_q <= !bm;
				if (!bm) begin
					pos_moved_q <= pos_moved_d;
					neg_moved_q <= neg_moved_d;
					if (changed) begin
						last_cmd_q <= cmd;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			if (bm) begin
				out_kind_q <= gp2arm_pkg::KIND_STOP;
				out_cmd_q  <= '0;
			end else begin
				out_kind_q <= gp2arm_pkg::KIND_JOINTS;
				out_cmd_q  <= cmd;
			end
		end
	end

endmodule

### rtl/gp2arm_checker.sv
// port-level checks for the gamepad to arm joint command block
module gp2arm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [gp2arm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// a stop beat carries no joint motion
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == gp2arm_pkg::KIND_STOP |-> m_axis_tdata == '0)
		else $error("stop beat with nonzero joint commands");

	// button and d-pad joints only ever move by one step
	a_pair_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(m_axis_tdata[15:8] == 8'd0 || m_axis_tdata[15:8] == 8'd1 ||
				m_axis_tdata[15:8] == 8'hFF) &&
			(m_axis_tdata[23:16] == 8'd0 || m_axis_tdata[23:16] == 8'd1 ||
				m_axis_tdata[23:16] == 8'hFF) &&
			(m_axis_tdata[47:40] == 8'd0 || m_axis_tdata[47:40] == 8'd1 ||
				m_axis_tdata[47:40] == 8'hFF))
		else $error("button joint command out of range");

	// analog joints stay within full scale
	a_analog_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:0] != 8'h80 && m_axis_tdata[31:24] != 8'h80 &&
			m_axis_tdata[39:32] != 8'h80)
		else $error("analog joint command beyond full scale");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
			$stable(m_axis_tuser))
		else $error("output beat changed while stalled");

endmodule

bind gamepad_to_arm_joint_commands gp2arm_checker u_gp2arm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
